// ===== sv/prti_pkg.sv =====
package prti_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int SLOT_W      = 7;
    localparam int ADDR_W      = 7;
    localparam int DRV_W       = 6;
    localparam int STATUS_W    = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BAD_ADDR = 3'd2,
        ST_BAD_DRV  = 3'd3,
        ST_ZERO     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_RESULT
    } fsm_t;

    // search probe handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [DRV_W-1:0]  drv;
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } probe_t;

    // write broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic [DRV_W-1:0]  drv;
    } wr_t;

endpackage

// ===== sv/prti_cell.sv =====
module prti_cell import prti_pkg::*; #(
    parameter int IDX = 1
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  probe_t probe_in,
    input  wr_t    wr,
    output probe_t probe_out
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic [ADDR_W-1:0] addr_reg;
    logic [DRV_W-1:0]  drv_reg;
    probe_t            probe_reg, probe_next;
    logic              match, empty;

    assign match = (addr_reg == probe_in.addr) && (drv_reg == probe_in.drv);
    assign empty = (addr_reg == '0) && (drv_reg == '0);

    always_comb begin
        probe_next = probe_in;
        // keep the lowest matching and lowest free slot seen so far
        if (!probe_in.hit && match) begin
            probe_next.hit      = 1'b1;
            probe_next.hit_slot = MY_SLOT;
        end
        if (!probe_in.free && empty) begin
            probe_next.free      = 1'b1;
            probe_next.free_slot = MY_SLOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg        <= '0;
            drv_reg         <= '0;
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg <= probe_next;
            if (wr.en && (wr.slot == MY_SLOT)) begin
                addr_reg <= wr.addr;
                drv_reg  <= wr.drv;
            end
        end
    end

    assign probe_out = probe_reg;

endmodule

// ===== sv/pair_register_table_insert.sv =====
// Pair registration table. Each input transaction carries a bus address and
// a driver id; the block answers with one result transaction holding a status
// and the slot written. Addresses above 127, driver ids above 63 and the
// all-zero pair are rejected at once, with no search: the block goes
// straight to the RESULT state and then back to IDLE for the next request.
// A valid pair travels as a probe down a chain of ENTRIES-1 slot
// cells, one cell per cycle, picking up the lowest slot already holding the
// pair and the lowest free slot. The write lands when the probe leaves the
// last cell; the result is then registered from the RESULT state, which
// waits while m_ holds a result that is not yet taken. Slot 0 is never
// used. The table is empty after reset. One request is in flight at a time;
// the next is accepted while the previous result still waits on m_.
module pair_register_table_insert import prti_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] bus_addr, [15:8] driver_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] status, [9:3] slot
);

    fsm_t              state_reg, state_next;
    status_t           res_status_reg, res_status_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [15:0]       m_tdata_reg, m_tdata_next;

    probe_t            chain [ENTRIES];
    probe_t            probe_head;
    wr_t               wr;

    logic [7:0]        in_addr, in_drv;
    logic              bad_addr, bad_drv, both_zero, accept, tail_done, out_free;

    assign in_addr   = s_tdata[7:0];
    assign in_drv    = s_tdata[15:8];
    assign bad_addr  = in_addr[7];
    assign bad_drv   = |in_drv[7:6];
    assign both_zero = (in_addr == '0) && (in_drv == '0);
    assign accept    = s_tvalid && s_tready;
    assign tail_done = chain[ENTRIES-1].valid;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign chain[0] = probe_head;

    for (genvar k = 1; k < ENTRIES; k++) begin : g_cell
        prti_cell #(.IDX(k)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .probe_in  (chain[k-1]),
            .wr        (wr),
            .probe_out (chain[k])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    if (bad_addr || bad_drv || both_zero) begin
                        state_next = FSM_RESULT;
                    end else begin
                        state_next = FSM_SCAN;
                    end
                end
            end
            FSM_SCAN: begin
                if (tail_done) begin
                    state_next = FSM_RESULT;
                end
            end
            FSM_RESULT: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = (state_reg == FSM_IDLE);
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        probe_head      = '0;
        probe_head.addr = in_addr[ADDR_W-1:0];
        probe_head.drv  = in_drv[DRV_W-1:0];

        wr      = '0;
        wr.addr = chain[ENTRIES-1].addr;
        wr.drv  = chain[ENTRIES-1].drv;

        case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    res_slot_next = '0;
                    if (bad_addr) begin
                        res_status_next = ST_BAD_ADDR;
                    end else if (bad_drv) begin
                        res_status_next = ST_BAD_DRV;
                    end else if (both_zero) begin
                        res_status_next = ST_ZERO;
                    end else begin
                        probe_head.valid = 1'b1;
                    end
                end
            end
            FSM_SCAN: begin
                if (tail_done) begin
                    if (chain[ENTRIES-1].hit) begin
                        res_status_next = ST_OK;
                        res_slot_next   = chain[ENTRIES-1].hit_slot;
                        wr.en           = 1'b1;
                        wr.slot         = chain[ENTRIES-1].hit_slot;
                    end else if (chain[ENTRIES-1].free) begin
                        res_status_next = ST_OK;
                        res_slot_next   = chain[ENTRIES-1].free_slot;
                        wr.en           = 1'b1;
                        wr.slot         = chain[ENTRIES-1].free_slot;
                    end else begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                    end
                end
            end
            FSM_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, res_slot_reg, res_status_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import prti_pkg::*;

    localparam int N_SLOTS       = ENTRIES_DEF;
    localparam int ADDR_LIMIT    = (1 << ADDR_W) - 1;
    localparam int DRV_LIMIT     = (1 << DRV_W) - 1;
    localparam int N_DIR         = 24;
    localparam int N_RANDOM      = 1526;
    localparam int HOLD_AT       = 400;
    localparam int PAUSE_AT      = 900;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 40;
    // longer than any normal gap between transactions and the long result hold
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } reg_result_t;

    typedef struct packed {
        logic [7:0]  addr;
        logic [7:0]  drv;
        bit          typed;
        reg_result_t res;
    } dir_row_t;

    localparam dir_row_t DIRECTED [N_DIR] = '{
        // both fields out of range: the address is reported first
        '{8'd255, 8'd255, 1'b1, '{ST_BAD_ADDR, 7'd0}},
        '{8'd128, 8'd0,   1'b1, '{ST_BAD_ADDR, 7'd0}},
        '{8'd127, 8'd64,  1'b1, '{ST_BAD_DRV,  7'd0}},
        '{8'd0,   8'd255, 1'b1, '{ST_BAD_DRV,  7'd0}},
        '{8'd0,   8'd0,   1'b1, '{ST_ZERO,     7'd0}},
        '{8'd127, 8'd63,  1'b1, '{ST_OK,       7'd1}},
        '{8'd0,   8'd1,   1'b1, '{ST_OK,       7'd2}},
        '{8'd1,   8'd0,   1'b1, '{ST_OK,       7'd3}},
        // pair already present: same slot again
        '{8'd127, 8'd63,  1'b1, '{ST_OK,       7'd1}},
        '{8'd85,  8'd42,  1'b0, '{ST_OK,       7'd0}},
        '{8'd42,  8'd21,  1'b0, '{ST_OK,       7'd0}},
        '{8'd127, 8'd0,   1'b0, '{ST_OK,       7'd0}},
        '{8'd0,   8'd63,  1'b0, '{ST_OK,       7'd0}},
        '{8'd3,   8'd5,   1'b0, '{ST_OK,       7'd0}},
        '{8'd64,  8'd32,  1'b0, '{ST_OK,       7'd0}},
        '{8'd100, 8'd7,   1'b0, '{ST_OK,       7'd0}},
        '{8'd17,  8'd60,  1'b0, '{ST_OK,       7'd0}},
        '{8'd126, 8'd62,  1'b0, '{ST_OK,       7'd0}},
        '{8'd9,   8'd9,   1'b0, '{ST_OK,       7'd0}},
        '{8'd120, 8'd1,   1'b0, '{ST_OK,       7'd0}},
        '{8'd2,   8'd33,  1'b0, '{ST_OK,       7'd0}},
        // every slot taken now
        '{8'd55,  8'd55,  1'b1, '{ST_FULL,     7'd0}},
        '{8'd0,   8'd1,   1'b0, '{ST_OK,       7'd0}},
        '{8'd0,   8'd0,   1'b1, '{ST_ZERO,     7'd0}}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [7:0] bus_addr, [15:8] driver_id
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [2:0] status, [9:3] slot

    // predictor copy of the table
    logic [ADDR_W-1:0] tbl_addr  [N_SLOTS];
    logic [DRV_W-1:0]  tbl_drv   [N_SLOTS];
    logic [2:0]        tbl_flags [N_SLOTS];

    reg_result_t pending_results [$];

    int  errors = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  n_alloc = 0, n_rewrite = 0, n_full = 0, n_reject = 0;
    int  idle_cycles = 0;
    bit  quiet_run = 1'b0;
    bit  hold_req = 1'b0;

    pair_register_table_insert #(.ENTRIES(N_SLOTS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic reg_result_t register_pair(input logic [7:0] addr,
                                                  input logic [7:0] drv);
        reg_result_t r;
        int hit;
        int free_idx;
        int chosen;
        r.status = ST_OK;
        r.slot   = '0;
        if (addr > ADDR_LIMIT) begin
            r.status = ST_BAD_ADDR;
        end else if (drv > DRV_LIMIT) begin
            r.status = ST_BAD_DRV;
        end else if (addr == 0 && drv == 0) begin
            r.status = ST_ZERO;
        end else begin
            hit = 0;
            free_idx = 0;
            // scan downward so the lowest match wins
            for (int i = N_SLOTS - 1; i >= 1; i--) begin
                if (tbl_addr[i] == addr[ADDR_W-1:0] && tbl_drv[i] == drv[DRV_W-1:0])
                    hit = i;
                if (tbl_addr[i] == '0 && tbl_drv[i] == '0)
                    free_idx = i;
            end
            chosen = (hit != 0) ? hit : free_idx;
            if (chosen == 0) begin
                r.status = ST_FULL;
            end else begin
                tbl_addr[chosen]  = addr[ADDR_W-1:0];
                tbl_drv[chosen]   = drv[DRV_W-1:0];
                tbl_flags[chosen] = '0;
                r.slot = SLOT_W'(chosen);
            end
        end
        case (r.status)
            ST_OK:   if (hit != 0) n_rewrite++; else n_alloc++;
            ST_FULL: n_full++;
            default: n_reject++;
        endcase
        return r;
    endfunction

    task automatic send_pair(input logic [7:0] addr, input logic [7:0] drv,
                             input bit typed, input reg_result_t typed_res);
        int gap;
        reg_result_t pred;
        gap = quiet_run ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {drv, addr};
        do @(posedge aclk); while (!s_tready);
        pred = register_pair(addr, drv);
        pending_results.push_back(typed ? typed_res : pred);
        items_sent++;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int stall;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            stall = quiet_run ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin : check_results
        reg_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                $display("%0t: result transaction with nothing expected, data %h",
                         $time, m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] != want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tdata[2:0]);
                    errors++;
                end
                if (m_tdata[9:3] != want.slot) begin
                    $display("%0t: slot expected %0d actual %0d",
                             $time, want.slot, m_tdata[9:3]);
                    errors++;
                end
                if (m_tdata[15:10] != '0) begin
                    $display("%0t: padding expected 0 actual %h", $time, m_tdata[15:10]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
            $display("** pair_register_table_insert: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int pick;
        int s;
        logic [7:0] addr;
        logic [7:0] drv;
        for (int i = 0; i < N_SLOTS; i++) begin
            tbl_addr[i]  = '0;
            tbl_drv[i]   = '0;
            tbl_flags[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_pair(DIRECTED[i].addr, DIRECTED[i].drv, DIRECTED[i].typed,
                      DIRECTED[i].res);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == HOLD_AT)
                hold_req = 1'b1;
            if (n == PAUSE_AT) begin
                // drain everything before going on
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending_results.size() != 0) @(posedge aclk);
            end
            quiet_run = ((n / 150) % 5 == 4);
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                addr = $urandom_range(ADDR_LIMIT + 1, 255);
                drv  = $urandom_range(0, 255);
            end else if (pick < 12) begin
                addr = $urandom_range(0, ADDR_LIMIT);
                drv  = $urandom_range(DRV_LIMIT + 1, 255);
            end else if (pick < 15) begin
                addr = '0;
                drv  = '0;
            end else if (pick < 65) begin
                // hit a stored pair so the match search lands on every slot
                s    = $urandom_range(1, N_SLOTS - 1);
                addr = {1'b0, tbl_addr[s]};
                drv  = {2'b00, tbl_drv[s]};
            end else begin
                addr = $urandom_range(0, ADDR_LIMIT);
                drv  = $urandom_range(0, DRV_LIMIT);
            end
            send_pair(addr, drv, 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests, checked %0d results: %0d new slots, %0d rewrites,",
                 items_sent, results_checked, n_alloc, n_rewrite);
        $display("%0d table-full answers, %0d rejects; one long result hold-off, one drain.",
                 n_full, n_reject);
        if (errors == 0) begin
            $display("** pair_register_table_insert: PASSED **");
        end else begin
            $display("** pair_register_table_insert: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/prti_pkg.sv
sv/prti_cell.sv
sv/pair_register_table_insert.sv
tb/tb_top.sv
